[rtl/rdpr_pkg.sv]
// Package for the reuse-distance page replacement block.
// Holds field widths, the controller state type and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package rdpr_pkg;

  // Configuration register: pages_in_use
  localparam int unsigned CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Reuse distance field and its saturation point
  localparam int unsigned DIST_W = 6;
  localparam int unsigned DIST_MAX = 63;

  // Width of the evicted page identifier on the result channel
  localparam int unsigned OUT_PAGE_W = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT,
    S_PUSH,
    S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // input transaction taken, clear per-item trackers
    logic scan;      // walk the stack looking for the page
    logic decide;    // latch hit/evict decision and result
    logic shift_rd;  // prime the first read of the gap-closing move
    logic shift;     // move one entry down per cycle
    logic push;      // write the accessed page on top
    logic out_load;  // copy the result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic need_remove;
    logic shift_more;
  } dp_status_t;

endpackage

[rtl/rdpr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rdpr_ram #(
  parameter int unsigned WIDTH = 38,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/rdpr_ctrl.sv]
// Controller state machine for the reuse-distance page replacement block.
// Depends on rdpr_pkg (state, command and status types).
`timescale 1ns / 1ps

module rdpr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  rdpr_pkg::dp_status_t status,
  output rdpr_pkg::ctrl_cmd_t  cmd
);

  import rdpr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output valid: set on load, cleared when the result transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = status.need_remove ? S_SHIFT_RD : S_PUSH;
      end
      S_SHIFT_RD: begin
        cmd.shift_rd = 1'b1;
        state_nxt    = status.shift_more ? S_SHIFT : S_PUSH;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (!status.shift_more) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/rdpr_dp.sv]
// Datapath for the reuse-distance page replacement block: stack RAM, resident
// count, scan trackers, gap-closing move and result registers.
// Depends on rdpr_pkg and rdpr_ram.
`timescale 1ns / 1ps

module rdpr_dp #(
  parameter int unsigned CAPACITY     = 64,
  parameter int unsigned PAGE_ID_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rdpr_pkg::ctrl_cmd_t             cmd,
  output rdpr_pkg::dp_status_t            status,
  input  logic [PAGE_ID_BITS-1:0]         in_page_id,
  input  logic                            cfg_we,
  input  logic [rdpr_pkg::CFG_W-1:0]      cfg_pages_in_use,
  output logic                            out_hit,
  output logic [rdpr_pkg::DIST_W-1:0]     out_reuse_distance,
  output logic                            out_evicted,
  output logic [rdpr_pkg::OUT_PAGE_W-1:0] out_evicted_page
);

  import rdpr_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned PW    = CNT_W + 1;
  localparam int unsigned CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned RAM_W = PAGE_ID_BITS + DIST_W;

  // Configuration and per-item state
  logic [CFG_W-1:0]        pages_in_use_r;
  logic [CNT_W-1:0]        count_r;
  logic [PAGE_ID_BITS-1:0] pid_r;
  logic [CNT_W-1:0]        ptr_r;
  logic                    chk_vld_r;
  logic [IDX_W-1:0]        chk_idx_r;
  logic                    hit_r;
  logic [IDX_W-1:0]        found_r;
  logic [DIST_W-1:0]       best_r;
  logic [IDX_W-1:0]        victim_r;
  logic [PAGE_ID_BITS-1:0] vic_page_r;
  logic                    remove_r;
  logic                    push_en_r;
  logic [IDX_W-1:0]        top_r;
  logic [DIST_W-1:0]       top_dist_r;

  // Pending result and output register
  logic                  res_hit_r;
  logic [DIST_W-1:0]     res_dist_r;
  logic                  res_evicted_r;
  logic [OUT_PAGE_W-1:0] res_evpage_r;
  logic                  out_hit_r;
  logic [DIST_W-1:0]     out_dist_r;
  logic                  out_evicted_r;
  logic [OUT_PAGE_W-1:0] out_evpage_r;

  // RAM port signals
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [RAM_W-1:0] ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [RAM_W-1:0] ram_rdata;

  logic [PAGE_ID_BITS-1:0] rd_page;
  logic [DIST_W-1:0]       rd_dist;
  logic [PW-1:0]           ptr_ext;
  logic [PW-1:0]           count_ext;
  logic                    issue_ok;
  logic                    match;
  logic [CMP_W-1:0]        cfg_ext;
  logic [CMP_W-1:0]        limit;
  logic                    evict_cond;
  logic                    need_remove;
  logic [CMP_W-1:0]        gap;
  logic [DIST_W-1:0]       hit_dist;
  logic                    shift_more;
  logic [IDX_W-1:0]        rm_idx;
  logic [PAGE_ID_BITS+OUT_PAGE_W-1:0] vic_page_wide;

  rdpr_ram #(
    .WIDTH (RAM_W),
    .DEPTH (CAPACITY)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_page   = ram_rdata[RAM_W-1:DIST_W];
  assign rd_dist   = ram_rdata[DIST_W-1:0];
  assign ptr_ext   = PW'(ptr_r);
  assign count_ext = PW'(count_r);
  assign issue_ok  = ptr_ext < count_ext;
  assign match     = chk_vld_r && (rd_page == pid_r);

  // Frame limit: zero acts as one, above capacity acts as capacity
  assign cfg_ext = CMP_W'(pages_in_use_r);
  always_comb begin
    if (cfg_ext == '0) begin
      limit = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(CAPACITY)) begin
      limit = CMP_W'(CAPACITY);
    end else begin
      limit = cfg_ext;
    end
  end

  assign evict_cond  = !hit_r && (CMP_W'(count_r) >= limit) && (count_r != '0);
  assign need_remove = hit_r || evict_cond;

  // Entries above the hit page, saturated to the field range
  assign gap      = CMP_W'(count_r - CNT_W'(found_r) - CNT_W'(1));
  assign hit_dist = (gap > CMP_W'(DIST_MAX)) ? DIST_W'(DIST_MAX) : DIST_W'(gap);
  assign rm_idx   = hit_r ? found_r : victim_r;

  assign vic_page_wide = {{OUT_PAGE_W{1'b0}}, vic_page_r};

  // Another move step needed: first read at ptr+1, then ptr+2 per step
  assign shift_more = cmd.shift_rd ? ((ptr_ext + PW'(1)) < count_ext)
                                   : ((ptr_ext + PW'(2)) < count_ext);

  assign status.scan_done   = match || (!issue_ok && !chk_vld_r);
  assign status.need_remove = need_remove;
  assign status.shift_more  = shift_more;

  // RAM address and data selection
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    if (cmd.scan) begin
      ram_re    = issue_ok;
      ram_raddr = ptr_r[IDX_W-1:0];
    end
    if (cmd.shift_rd) begin
      ram_re    = shift_more;
      ram_raddr = IDX_W'(ptr_ext + PW'(1));
    end
    if (cmd.shift) begin
      ram_re    = shift_more;
      ram_raddr = IDX_W'(ptr_ext + PW'(2));
      ram_we    = 1'b1;
      ram_waddr = ptr_r[IDX_W-1:0];
      ram_wdata = ram_rdata;
    end
    if (cmd.push) begin
      ram_we    = push_en_r;
      ram_waddr = top_r;
      ram_wdata = {pid_r, top_dist_r};
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pages_in_use_r <= CFG_RESET;
    end else if (cfg_we) begin
      pages_in_use_r <= cfg_pages_in_use;
    end
  end

  // Resident count: grows only when a page is appended without removal
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.push && push_en_r && !remove_r) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  // Scan, decision and move control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
      hit_r     <= 1'b0;
      ptr_r     <= '0;
    end else if (cmd.accept) begin
      chk_vld_r <= 1'b0;
      hit_r     <= 1'b0;
      ptr_r     <= '0;
    end else if (cmd.scan) begin
      chk_vld_r <= issue_ok;
      if (issue_ok) begin
        ptr_r <= ptr_r + CNT_W'(1);
      end
      if (match) begin
        hit_r <= 1'b1;
      end
    end else if (cmd.decide) begin
      ptr_r <= CNT_W'(rm_idx);
    end else if (cmd.shift) begin
      ptr_r <= ptr_r + CNT_W'(1);
    end
  end

  // Per-item payload trackers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pid_r    <= in_page_id;
      best_r   <= '0;
      victim_r <= '0;
      found_r  <= '0;
    end
    if (cmd.scan) begin
      chk_idx_r <= ptr_r[IDX_W-1:0];
      if (match) begin
        found_r <= chk_idx_r;
      end
      // First entry with the largest distance; slot 0 seeds the search
      if (chk_vld_r && ((rd_dist > best_r) || (chk_idx_r == '0))) begin
        best_r     <= rd_dist;
        victim_r   <= chk_idx_r;
        vic_page_r <= rd_page;
      end
    end
    if (cmd.decide) begin
      remove_r      <= need_remove;
      push_en_r     <= need_remove || (count_ext < PW'(CAPACITY));
      top_r         <= need_remove ? IDX_W'(count_r - CNT_W'(1)) : IDX_W'(count_r);
      top_dist_r    <= hit_r ? hit_dist : '0;
      res_hit_r     <= hit_r;
      res_dist_r    <= hit_r ? hit_dist : '0;
      res_evicted_r <= evict_cond;
      res_evpage_r  <= evict_cond ? vic_page_wide[OUT_PAGE_W-1:0] : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hit_r     <= res_hit_r;
      out_dist_r    <= res_dist_r;
      out_evicted_r <= res_evicted_r;
      out_evpage_r  <= res_evpage_r;
    end
  end

  assign out_hit            = out_hit_r;
  assign out_reuse_distance = out_dist_r;
  assign out_evicted        = out_evicted_r;
  assign out_evicted_page   = out_evpage_r;

  // Checks
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_ext <= PW'(CAPACITY))
    else $error("resident count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r)) ||
                     (count_r == $past(count_r) + CNT_W'(1)))
    else $error("resident count changed by other than zero or one");

  a_write_in_stack: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (PW'(ram_waddr) <= count_ext))
    else $error("stack write above the resident entries");

  a_shift_below_top: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> ((ptr_ext + PW'(1)) < count_ext))
    else $error("entry move outside the resident range");

endmodule

[rtl/reuse_distance_page_replacement.sv]
// Reuse-distance page replacement: recency stack with max-distance victim.
// Top level; depends on rdpr_pkg, rdpr_ctrl, rdpr_dp (and rdpr_ram below it).
//
// Usage:
//   Input channel (in_valid/in_ready, in_page_id): one page access per
//   transaction. in_ready is high only while the block is idle.
//   Result channel (out_valid/out_ready): one result per access with hit,
//   reuse_distance, evicted and evicted_page (zero when nothing evicted).
//   Config channel (cfg_valid/cfg_ready, cfg_pages_in_use): frame limit,
//   always ready; write it only while no access is in flight.
//   Sequence: each access scans the N resident entries (a hit stops the
//   scan early), then closes the gap left by the hit or the victim, then
//   pushes the page and posts the result. The pace of each access is set
//   by the single read port of the stack RAM, which every scan and move
//   step goes through.
//   Reset: the stack is empty and the frame limit is 64; no clearing pass.
//   Stall: a result waits in the output register; the next access is taken
//   and processed, and it holds at its end until the output register frees.
`timescale 1ns / 1ps

module reuse_distance_page_replacement #(
  parameter int unsigned CAPACITY     = 64,
  parameter int unsigned PAGE_ID_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [PAGE_ID_BITS-1:0]         in_page_id,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output logic [rdpr_pkg::DIST_W-1:0]     out_reuse_distance,
  output logic                            out_evicted,
  output logic [rdpr_pkg::OUT_PAGE_W-1:0] out_evicted_page,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rdpr_pkg::CFG_W-1:0]      cfg_pages_in_use
);

  import rdpr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  rdpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rdpr_dp #(
    .CAPACITY     (CAPACITY),
    .PAGE_ID_BITS (PAGE_ID_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_page_id         (in_page_id),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_pages_in_use   (cfg_pages_in_use),
    .out_hit            (out_hit),
    .out_reuse_distance (out_reuse_distance),
    .out_evicted        (out_evicted),
    .out_evicted_page   (out_evicted_page)
  );

endmodule
